@@ src/assert_macros.svh @@
// Assertion macros shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pca_pkg.sv @@
// Shared types and constants of the collision avoidance block
package pca_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int DIFF_W         = 31;
    localparam int CLAMP_W        = 34;
    localparam logic signed [CLAMP_W-1:0] DIFF_LIM = 34'sd1073741823;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    localparam logic [CFG_W-1:0] MAX_ACCEL_RST       = 16'd2560;
    localparam logic [CFG_W-1:0] TIME_HORIZON_RST    = 16'd19661;
    localparam logic [CFG_W-1:0] COMBINED_RADIUS_RST = 16'd10240;

    localparam int QUEUE_DEPTH = 2;

    // iterative unit sizes
    localparam int OP_W        = 62;
    localparam int SQ_W        = 128;
    localparam int ROOT_W      = 64;
    localparam int DIV_W       = 62;
    localparam int DVD_W       = 64;
    localparam int CNT_W       = 7;
    localparam int MUL_STEPS   = 62;
    localparam int SQRT_STEPS  = 64;
    localparam int TTC_STEPS   = 16;
    localparam int MAG_STEPS   = 32;
    localparam int STEER_STEPS = 47;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ACCEL       = 2'd0,
        CFG_TIME_HORIZON    = 2'd1,
        CFG_COMBINED_RADIUS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] xx;
        logic signed [DIFF_W-1:0] xy;
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] vy;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] max_accel;
        logic [CFG_W-1:0] time_horizon;
        logic [CFG_W-1:0] combined_radius;
    } cfg_t;

endpackage

@@ src/pca_if.sv @@
// Handshake channel interfaces for neighbour words and steering words
interface pca_in_if #(
    parameter int COORD_BITS = pca_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] self_pos_x;
    logic signed [COORD_BITS-1:0] self_pos_y;
    logic signed [COORD_BITS-1:0] self_vel_x;
    logic signed [COORD_BITS-1:0] self_vel_y;
    logic signed [COORD_BITS-1:0] other_pos_x;
    logic signed [COORD_BITS-1:0] other_pos_y;
    logic signed [COORD_BITS-1:0] other_vel_x;
    logic signed [COORD_BITS-1:0] other_vel_y;
    logic                         last_neighbour;

    modport source (
        output valid, self_pos_x, self_pos_y, self_vel_x, self_vel_y,
               other_pos_x, other_pos_y, other_vel_x, other_vel_y, last_neighbour,
        input  ready
    );
    modport sink (
        input  valid, self_pos_x, self_pos_y, self_vel_x, self_vel_y,
               other_pos_x, other_pos_y, other_vel_x, other_vel_y, last_neighbour,
        output ready
    );
endinterface

interface pca_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pca_pkg::OUT_W-1:0] steer_x;
    logic signed [pca_pkg::OUT_W-1:0] steer_y;

    modport source (output valid, steer_x, steer_y, input ready);
    modport sink (input valid, steer_x, steer_y, output ready);
endinterface

@@ src/pca_fifo.sv @@
// Short queue of classified neighbour words between front and back
module pca_fifo #(
    parameter int DEPTH = pca_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pca_pkg::item_t push_item,
    input  logic           push_valid,
    output logic           push_ready,
    output pca_pkg::item_t pop_item,
    output logic           pop_valid,
    input  logic           pop_ready
);
    `include "assert_macros.svh"

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pca_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push_fire, pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_count_up, clk, rst_n, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "queue count lost a word")

endmodule

@@ src/pca_front.sv @@
// Front end: accept neighbour words, form clamped relative position and velocity
module pca_front #(
    parameter int COORD_BITS = pca_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pca_in_if.sink         neigh,
    output pca_pkg::item_t push_item,
    output logic           push_valid,
    input  logic           push_ready
);
    localparam int CW = pca_pkg::CLAMP_W;
    localparam int DW = pca_pkg::DIFF_W;

    logic           valid_reg, valid_next;
    pca_pkg::item_t item_reg;
    pca_pkg::item_t item_next;
    logic           accept;

    function automatic logic signed [DW-1:0] clamp_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [CW-1:0]       e;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        e = {{(CW - COORD_BITS - 1){d[COORD_BITS]}}, d};
        if (e > pca_pkg::DIFF_LIM)
        begin
            return pca_pkg::DIFF_LIM[DW-1:0];
        end
        if (e < -pca_pkg::DIFF_LIM)
        begin
            return -pca_pkg::DIFF_LIM[DW-1:0];
        end
        return e[DW-1:0];
    endfunction

    assign neigh.ready = !valid_reg || push_ready;
    assign accept      = neigh.valid && neigh.ready;
    assign push_valid  = valid_reg;
    assign push_item   = item_reg;

    always_comb
    begin
        item_next.xx   = clamp_diff(neigh.other_pos_x, neigh.self_pos_x);
        item_next.xy   = clamp_diff(neigh.other_pos_y, neigh.self_pos_y);
        item_next.vx   = clamp_diff(neigh.self_vel_x, neigh.other_vel_x);
        item_next.vy   = clamp_diff(neigh.self_vel_y, neigh.other_vel_y);
        item_next.last = neigh.last_neighbour;
        valid_next     = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ src/pca_back.sv @@
// Back end: sequencer with shared multiplier, serial multipliers, root and divide units
module pca_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pca_pkg::item_t pop_item,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  pca_pkg::cfg_t  cfg,
    pca_out_if.source      steer
);
    `include "assert_macros.svh"

    localparam int OP_W  = pca_pkg::OP_W;
    localparam int SQ_W  = pca_pkg::SQ_W;
    localparam int RW    = pca_pkg::ROOT_W;
    localparam int DV_W  = pca_pkg::DIV_W;
    localparam int DD_W  = pca_pkg::DVD_W;
    localparam int CNT_W = pca_pkg::CNT_W;

    typedef enum logic [30:0] {
        S_IDLE  = 31'b1 << 0,
        S_M1    = 31'b1 << 1,
        S_M2    = 31'b1 << 2,
        S_M3    = 31'b1 << 3,
        S_M4    = 31'b1 << 4,
        S_M5    = 31'b1 << 5,
        S_M6    = 31'b1 << 6,
        S_M7    = 31'b1 << 7,
        S_M8    = 31'b1 << 8,
        S_CHK   = 31'b1 << 9,
        S_MUL   = 31'b1 << 10,
        S_CMP   = 31'b1 << 11,
        S_SQRT1 = 31'b1 << 12,
        S_NUM   = 31'b1 << 13,
        S_DIVT  = 31'b1 << 14,
        S_TTC   = 31'b1 << 15,
        S_SX    = 31'b1 << 16,
        S_SY    = 31'b1 << 17,
        S_PM    = 31'b1 << 18,
        S_DX2   = 31'b1 << 19,
        S_DY2   = 31'b1 << 20,
        S_DIVM  = 31'b1 << 21,
        S_SQ2L  = 31'b1 << 22,
        S_SQRT2 = 31'b1 << 23,
        S_LEN   = 31'b1 << 24,
        S_CXW   = 31'b1 << 25,
        S_DIVX  = 31'b1 << 26,
        S_CYL   = 31'b1 << 27,
        S_DIVY  = 31'b1 << 28,
        S_ACC   = 31'b1 << 29,
        S_FIN   = 31'b1 << 30
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    pca_pkg::item_t        it_reg, it_next;
    logic signed [63:0]    c_reg, c_next;
    logic signed [63:0]    b_reg, b_next;
    logic [63:0]           a_reg, a_next;
    logic [63:0]           p_reg;
    logic [31:0]           mul_a, mul_b;
    logic [OP_W-1:0]       hi0_reg, hi0_next, lo0_reg, lo0_next, mc0_reg, mc0_next;
    logic [OP_W-1:0]       hi1_reg, hi1_next, lo1_reg, lo1_next, mc1_reg, mc1_next;
    logic [SQ_W-1:0]       sqn_reg, sqn_next;
    logic [RW+1:0]         srem_reg, srem_next;
    logic [RW-1:0]         root_reg, root_next;
    logic [DV_W-1:0]       drem_reg, drem_next;
    logic [DD_W-1:0]       dvd_reg, dvd_next;
    logic [DV_W-1:0]       dvs_reg, dvs_next;
    logic [DD_W-1:0]       quo_reg, quo_next;
    logic [15:0]           ttc_reg, ttc_next;
    logic signed [32:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]           pm_reg, pm_next;
    logic [63:0]           lsq_reg, lsq_next;
    logic [15:0]           mag_reg, mag_next;
    logic [31:0]           len_reg, len_next;
    logic [15:0]           cx_reg, cx_next;
    logic signed [31:0]    sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [31:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  fin_emit;

    logic [OP_W:0]         msum0, msum1;
    logic [RW+3:0]         sq_sh, sq_diff;
    logic [RW+1:0]         sq_trial;
    logic                  sq_ge;
    logic [DV_W:0]         dv_sh, dv_diff;
    logic                  dv_ge;
    logic [2*OP_W-1:0]     bb, ac;
    logic [OP_W-1:0]       num;
    logic [15:0]           ttc_w;

    function automatic logic [31:0] mag31(input logic signed [30:0] v);
        logic [30:0] m;
        m = v[30] ? 31'(-v) : v;
        return {1'b0, m};
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : v;
        return m[31:0];
    endfunction

    // velocity times ttc, rounded half away from zero back to Q.8
    function automatic logic signed [32:0] scaled(input logic [63:0] p, input logic neg);
        logic [46:0] t;
        logic [32:0] q;
        t = p[46:0] + 47'd32768;
        q = {2'b00, t[46:16]};
        return neg ? -q : q;
    endfunction

    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] s,
        input logic [15:0]        m,
        input logic               neg
    );
        logic signed [32:0] e;
        logic signed [32:0] t;
        e = neg ? -$signed({17'b0, m}) : $signed({17'b0, m});
        t = {s[31], s} + e;
        if (t[32] != t[31])
        begin
            return t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return t[31:0];
    endfunction

    assign pop_ready     = (state_reg == S_IDLE);
    assign steer.valid   = out_valid_reg;
    assign steer.steer_x = ox_reg;
    assign steer.steer_y = oy_reg;
    assign fin_emit      = (state_reg == S_FIN) && it_reg.last
                           && (!out_valid_reg || steer.ready);

    // iterative unit datapaths
    assign msum0    = {1'b0, hi0_reg} + (lo0_reg[0] ? {1'b0, mc0_reg} : '0);
    assign msum1    = {1'b0, hi1_reg} + (lo1_reg[0] ? {1'b0, mc1_reg} : '0);
    assign sq_sh    = {srem_reg, sqn_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_sh >= {2'b00, sq_trial};
    assign sq_diff  = sq_sh - {2'b00, sq_trial};
    assign dv_sh    = {drem_reg, dvd_reg[DD_W-1]};
    assign dv_ge    = dv_sh >= {1'b0, dvs_reg};
    assign dv_diff  = dv_sh - {1'b0, dvs_reg};
    assign bb       = {hi0_reg, lo0_reg};
    assign ac       = {hi1_reg, lo1_reg};
    assign num      = b_reg[OP_W-1:0] - root_reg[OP_W-1:0];
    assign ttc_w    = quo_reg[15:0];

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_M1:                  begin mul_a = mag31(it_reg.xx); mul_b = mag31(it_reg.xx); end
            S_M2:                  begin mul_a = mag31(it_reg.xy); mul_b = mag31(it_reg.xy); end
            S_M3:                  begin mul_a = {16'b0, cfg.combined_radius};
                                         mul_b = {16'b0, cfg.combined_radius}; end
            S_M4:                  begin mul_a = mag31(it_reg.vx); mul_b = mag31(it_reg.vx); end
            S_M5:                  begin mul_a = mag31(it_reg.vy); mul_b = mag31(it_reg.vy); end
            S_M6:                  begin mul_a = mag31(it_reg.xx); mul_b = mag31(it_reg.vx); end
            S_M7:                  begin mul_a = mag31(it_reg.xy); mul_b = mag31(it_reg.vy); end
            S_TTC:                 begin mul_a = mag31(it_reg.vx); mul_b = {16'b0, ttc_w}; end
            S_SX:                  begin mul_a = mag31(it_reg.vy); mul_b = {16'b0, ttc_reg}; end
            S_SY:                  begin mul_a = {16'b0, cfg.max_accel};
                                         mul_b = {16'b0, cfg.time_horizon - ttc_reg}; end
            S_PM:                  begin mul_a = mag33(dx_reg); mul_b = mag33(dx_reg); end
            S_DX2:                 begin mul_a = mag33(dy_reg); mul_b = mag33(dy_reg); end
            S_LEN:                 begin mul_a = mag33(dx_reg); mul_b = {16'b0, mag_reg}; end
            S_CXW, S_DIVX, S_CYL:  begin mul_a = mag33(dy_reg); mul_b = {16'b0, mag_reg}; end
            default:               begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        it_next        = it_reg;
        c_next         = c_reg;
        b_next         = b_reg;
        a_next         = a_reg;
        hi0_next       = hi0_reg;
        lo0_next       = lo0_reg;
        mc0_next       = mc0_reg;
        hi1_next       = hi1_reg;
        lo1_next       = lo1_reg;
        mc1_next       = mc1_reg;
        sqn_next       = sqn_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        ttc_next       = ttc_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        pm_next        = pm_reg;
        lsq_next       = lsq_reg;
        mag_next       = mag_reg;
        len_next       = len_reg;
        cx_next        = cx_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        out_valid_next = out_valid_reg;

        if (steer.valid && steer.ready)
        begin
            out_valid_next = 1'b0;
        end

        // advance whichever iterative unit the state owns
        if (state_reg == S_MUL)
        begin
            hi0_next = msum0[OP_W:1];
            lo0_next = {msum0[0], lo0_reg[OP_W-1:1]};
            hi1_next = msum1[OP_W:1];
            lo1_next = {msum1[0], lo1_reg[OP_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
        end
        if ((state_reg == S_SQRT1) || (state_reg == S_SQRT2))
        begin
            sqn_next  = {sqn_reg[SQ_W-3:0], 2'b00};
            srem_next = sq_ge ? sq_diff[RW+1:0] : sq_sh[RW+1:0];
            root_next = {root_reg[RW-2:0], sq_ge};
            cnt_next  = cnt_reg + 1'b1;
        end
        if ((state_reg == S_DIVT) || (state_reg == S_DIVM) || (state_reg == S_DIVX)
            || (state_reg == S_DIVY))
        begin
            drem_next = dv_ge ? dv_diff[DV_W-1:0] : dv_sh[DV_W-1:0];
            quo_next  = {quo_reg[DD_W-2:0], dv_ge};
            dvd_next  = {dvd_reg[DD_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    it_next    = pop_item;
                    state_next = S_M1;
                end
            end
            S_M1: state_next = S_M2;
            S_M2:
            begin
                c_next     = p_reg;
                state_next = S_M3;
            end
            S_M3:
            begin
                c_next     = c_reg + p_reg;
                state_next = S_M4;
            end
            S_M4:
            begin
                c_next     = c_reg - p_reg;
                state_next = S_M5;
            end
            S_M5:
            begin
                a_next     = p_reg;
                state_next = S_M6;
            end
            S_M6:
            begin
                a_next     = a_reg + p_reg;
                state_next = S_M7;
            end
            S_M7:
            begin
                b_next     = (it_reg.xx[30] ^ it_reg.vx[30]) ? -p_reg : p_reg;
                state_next = S_M8;
            end
            S_M8:
            begin
                b_next     = b_reg + ((it_reg.xy[30] ^ it_reg.vy[30]) ? -p_reg : p_reg);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // overlapping, receding, or no horizon: drop the neighbour
                if ((cfg.time_horizon == '0) || c_reg[63] || b_reg[63] || (b_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    hi0_next   = '0;
                    lo0_next   = b_reg[OP_W-1:0];
                    mc0_next   = b_reg[OP_W-1:0];
                    hi1_next   = '0;
                    lo1_next   = c_reg[OP_W-1:0];
                    mc1_next   = a_reg[OP_W-1:0];
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::MUL_STEPS - 1))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (bb <= ac)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    sqn_next   = {{(SQ_W - 2*OP_W){1'b0}}, bb - ac};
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT1;
                end
            end
            S_SQRT1:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                if ((num == '0) || (num >= a_reg[OP_W-1:0]))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    drem_next  = num;
                    dvd_next   = '0;
                    dvs_next   = a_reg[DV_W-1:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::TTC_STEPS - 1))
                begin
                    state_next = S_TTC;
                end
            end
            S_TTC:
            begin
                ttc_next   = ttc_w;
                state_next = (ttc_w > cfg.time_horizon) ? S_FIN : S_SX;
            end
            S_SX:
            begin
                dx_next    = scaled(p_reg, it_reg.vx[30]) - {{2{it_reg.xx[30]}}, it_reg.xx};
                state_next = S_SY;
            end
            S_SY:
            begin
                dy_next    = scaled(p_reg, it_reg.vy[30]) - {{2{it_reg.xy[30]}}, it_reg.xy};
                state_next = S_PM;
            end
            S_PM:
            begin
                pm_next    = p_reg[31:0];
                state_next = S_DX2;
            end
            S_DX2:
            begin
                lsq_next   = p_reg;
                state_next = S_DY2;
            end
            S_DY2:
            begin
                lsq_next = lsq_reg + p_reg;
                if ((dx_reg == '0) && (dy_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    drem_next  = '0;
                    dvd_next   = {pm_reg, 32'b0};
                    dvs_next   = {{(DV_W - 16){1'b0}}, cfg.time_horizon};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVM;
                end
            end
            S_DIVM:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::MAG_STEPS - 1))
                begin
                    state_next = S_SQ2L;
                end
            end
            S_SQ2L:
            begin
                mag_next   = quo_reg[15:0];
                sqn_next   = {{(SQ_W - 64){1'b0}}, lsq_reg};
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_SQRT2;
            end
            S_SQRT2:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                len_next   = root_reg[31:0];
                state_next = (root_reg == '0) ? S_FIN : S_CXW;
            end
            S_CXW:
            begin
                drem_next  = '0;
                dvd_next   = {p_reg[46:0], 17'b0};
                dvs_next   = {{(DV_W - 32){1'b0}}, len_reg};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::STEER_STEPS - 1))
                begin
                    state_next = S_CYL;
                end
            end
            S_CYL:
            begin
                cx_next    = quo_reg[15:0];
                drem_next  = '0;
                dvd_next   = {p_reg[46:0], 17'b0};
                dvs_next   = {{(DV_W - 32){1'b0}}, len_reg};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                if (cnt_reg == CNT_W'(pca_pkg::STEER_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_x_next = sat_add(sum_x_reg, cx_reg, dx_reg[32]);
                sum_y_next = sat_add(sum_y_reg, quo_reg[15:0], dy_reg[32]);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!it_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (fin_emit)
                begin
                    ox_next        = sum_x_reg;
                    oy_next        = sum_y_reg;
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= mul_a * mul_b;
        it_reg   <= it_next;
        c_reg    <= c_next;
        b_reg    <= b_next;
        a_reg    <= a_next;
        hi0_reg  <= hi0_next;
        lo0_reg  <= lo0_next;
        mc0_reg  <= mc0_next;
        hi1_reg  <= hi1_next;
        lo1_reg  <= lo1_next;
        mc1_reg  <= mc1_next;
        sqn_reg  <= sqn_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        drem_reg <= drem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        ttc_reg  <= ttc_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        pm_reg   <= pm_next;
        lsq_reg  <= lsq_next;
        mag_reg  <= mag_next;
        len_reg  <= len_next;
        cx_reg   <= cx_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
    end

    `ASSERT_IMPL(a_out_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_FIN), "steering word raised outside finish")
    `ASSERT_NEXT(a_sum_cleared, clk, rst_n, fin_emit, (sum_x_reg == '0) && (sum_y_reg == '0), "sum not cleared after emit")
    `ASSERT_NEXT(a_pop_starts, clk, rst_n, pop_valid && pop_ready, state_reg == S_M1, "popped word not started")

endmodule

@@ src/predictive_collision_avoidance_top.sv @@
// Top level of the predictive collision avoidance block
// One neighbour word enters per handshake on neigh; the front stage forms the
// clamped relative position and velocity and parks the word in a two-entry
// queue, so the input keeps accepting, until that queue is full, while the
// back end works and while a steering word waits on steer. The back end
// takes one neighbour at a time; some are dropped early (overlapping,
// receding, no horizon and more), others go the full way; the time each takes is set by
// the back end's iterative units: two 62-step serial multipliers running side
// by side for b*b and a*c, a 64-step square root used twice (discriminant and
// offset length), and a shared restoring divider used for time to collision
// (16 steps), magnitude (32 steps) and each steering component (47 steps).
// A steering word appears only after a neighbour flagged last_neighbour, and
// the running sum is cleared at that point. Configuration is a plain write
// port: index 0 max_accel, 1 time_horizon, 2 combined_radius, others ignored;
// write it only while the block is idle.
module predictive_collision_avoidance_top #(
    parameter int COORD_BITS = pca_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = pca_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pca_in_if.sink                          neigh,
    pca_out_if.source                       steer,
    input  logic                            cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pca_pkg::CFG_W-1:0]       cfg_wdata
);
    // configuration registers
    pca_pkg::cfg_t  cfg_reg, cfg_next;

    // front to queue, queue to back
    pca_pkg::item_t push_item;
    logic           push_valid;
    logic           push_ready;
    pca_pkg::item_t pop_item;
    logic           pop_valid;
    logic           pop_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pca_pkg::CFG_MAX_ACCEL:       cfg_next.max_accel       = cfg_wdata;
                pca_pkg::CFG_TIME_HORIZON:    cfg_next.time_horizon    = cfg_wdata;
                pca_pkg::CFG_COMBINED_RADIUS: cfg_next.combined_radius = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_accel       <= pca_pkg::MAX_ACCEL_RST;
            cfg_reg.time_horizon    <= pca_pkg::TIME_HORIZON_RST;
            cfg_reg.combined_radius <= pca_pkg::COMBINED_RADIUS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // accept and classify
    pca_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .neigh      (neigh),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // hold words between the two halves
    pca_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // solve, scale and accumulate
    pca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .cfg       (cfg_reg),
        .steer     (steer)
    );

endmodule
